/* design/tsb_pkg.sv */
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared types and constants for the bilinear texture sampler.
// ----------------------------------------------------------------------------
`default_nettype none
package tsb_pkg;
  localparam int AddrBits = 16;
  localparam int FracBits = 16;
  localparam int DimBits  = 9;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegMode   = 2'd2;

  localparam logic ActWrite  = 1'b0;
  localparam logic ActSample = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ADDR,
    ST_FETCH,
    ST_BLEND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic addr;
    logic fetch;
    logic blend;
    logic [1:0] tap;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic nearest;
  } sts_t;
endpackage
`default_nettype wire

/* design/tsb_ctrl.sv */
// ----------------------------------------------------------------------------
// tsb_ctrl
// Sequencer: scale, address, fetch one or four texels, blend, hand off.
// ----------------------------------------------------------------------------
`default_nettype none
module tsb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic           out_free,
  input  wire tsb_pkg::sts_t  sts,
  output tsb_pkg::cmd_t       cmd,
  output logic                busy,
  output logic                res_load
);
  import tsb_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire && !sts.is_write) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_ADDR;
      ST_ADDR: begin
        state_nxt = ST_FETCH;
        cnt_nxt   = '0;
      end
      ST_FETCH: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd5 || (sts.nearest && cnt_r == 3'd2)) state_nxt = ST_BLEND;
      end
      ST_BLEND: state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    busy     = 1'b1;
    res_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = in_fire;
      end
      ST_SCALE: cmd.scale = 1'b1;
      ST_ADDR:  cmd.addr  = 1'b1;
      ST_FETCH: begin
        cmd.fetch = (cnt_r != 3'd0) && (cnt_r <= (sts.nearest ? 3'd1 : 3'd4));
        cmd.tap   = cnt_r[1:0] - 2'd1;
      end
      ST_BLEND: cmd.blend = 1'b1;
      ST_OUT:   res_load = out_free;
      default:  busy = 1'b1;
    endcase
  end
endmodule
`default_nettype wire

/* design/tsb_dp.sv */
// ----------------------------------------------------------------------------
// tsb_dp
// Datapath: texel memory, coordinate scaling, addressing and blending.
// ----------------------------------------------------------------------------
`default_nettype none
module tsb_dp (
  input  wire logic                       clk,
  input  wire tsb_pkg::cmd_t              cmd,
  input  wire logic [tsb_pkg::DimBits-1:0] w_eff,
  input  wire logic [tsb_pkg::DimBits-1:0] h_eff,
  input  wire logic                       mode,
  input  wire logic                       action,
  input  wire logic [tsb_pkg::AddrBits-1:0] texel_addr,
  input  wire logic [23:0]                texel_rgb,
  input  wire logic [tsb_pkg::FracBits-1:0] u_coord,
  input  wire logic [tsb_pkg::FracBits-1:0] v_coord,
  output tsb_pkg::sts_t                   sts,
  output logic [23:0]                     result
);
  import tsb_pkg::*;

  logic [23:0] mem [0:(1<<AddrBits)-1];
  logic [23:0] rd_r;
  logic [AddrBits-1:0] rd_addr;

  logic [FracBits-1:0] u_r, v_r;
  logic                nearest_r;
  logic [FracBits+7:0] pi_r, pj_r;
  logic [7:0]          p_r, q_r, p1_r, q1_r;
  logic [FracBits-1:0] dx_r, dy_r;
  logic [AddrBits-1:0] a00_r, a10_r, a01_r, a11_r;
  logic [23:0]         t_r [0:3];
  logic [23:0]         res_r;

  assign sts.is_write = (action == ActWrite);
  assign sts.nearest  = nearest_r;
  assign result       = res_r;

  always_comb begin
    unique case (cmd.tap)
      2'd0:    rd_addr = a00_r;
      2'd1:    rd_addr = a10_r;
      2'd2:    rd_addr = a01_r;
      default: rd_addr = a11_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load && action == ActWrite) mem[texel_addr] <= texel_rgb;
    rd_r <= mem[rd_addr];
  end

  logic [FracBits+7:0] pi_c, pj_c, pin, pjn;
  logic [8:0] xn, yn;
  logic [7:0] wm, hm, pc, qc;
  always_comb begin
    wm   = 8'(w_eff - 9'd1);
    hm   = 8'(h_eff - 9'd1);
    pi_c = (FracBits+8)'(u_r) * (FracBits+8)'(wm);
    pj_c = (FracBits+8)'(v_r) * (FracBits+8)'(hm);
    pin  = pi_r + (FracBits+8)'(1 << (FracBits-1));
    pjn  = pj_r + (FracBits+8)'(1 << (FracBits-1));
    xn   = nearest_r ? {1'b0, pin[FracBits+7:FracBits]} : {1'b0, pi_r[FracBits+7:FracBits]};
    yn   = nearest_r ? {1'b0, pjn[FracBits+7:FracBits]} : {1'b0, pj_r[FracBits+7:FracBits]};
    pc   = (xn > {1'b0, wm}) ? wm : xn[7:0];
    qc   = (yn > {1'b0, hm}) ? hm : yn[7:0];
  end

  logic [16:0] row0, row1;
  always_comb begin
    row0 = 17'(q_r) * 17'(w_eff);
    row1 = 17'(q1_r) * 17'(w_eff);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u_r       <= u_coord;
      v_r       <= v_coord;
      nearest_r <= ~mode;
    end
    if (cmd.scale) begin
      pi_r <= pi_c;
      pj_r <= pj_c;
    end
    if (cmd.addr) begin
      p_r  <= pc;
      q_r  <= qc;
      p1_r <= (pc == wm) ? wm : pc + 8'd1;
      q1_r <= (qc == hm) ? hm : qc + 8'd1;
      dx_r <= pi_r[FracBits-1:0];
      dy_r <= pj_r[FracBits-1:0];
    end
    a00_r <= AddrBits'(row0 + 17'(p_r));
    a10_r <= AddrBits'(row0 + 17'(p1_r));
    a01_r <= AddrBits'(row1 + 17'(p_r));
    a11_r <= AddrBits'(row1 + 17'(p1_r));
  end

  // Fetch pipeline: data for the tap issued last cycle arrives in rd_r.
  logic [1:0] tap_d_r;
  logic       fetch_d_r;
  always_ff @(posedge clk) begin
    tap_d_r   <= cmd.tap;
    fetch_d_r <= cmd.fetch;
    if (fetch_d_r) t_r[tap_d_r] <= rd_r;
  end

  logic [FracBits:0] wx0, wy0;
  logic [2*FracBits:0] w00_r, w10_r, w01_r, w11_r;
  always_comb begin
    wx0 = (FracBits+1)'(1 << FracBits) - (FracBits+1)'(dx_r);
    wy0 = (FracBits+1)'(1 << FracBits) - (FracBits+1)'(dy_r);
  end

  // The weights settle during the fetch cycles, well before the blend.
  always_ff @(posedge clk) begin
    w00_r <= (2*FracBits+1)'(wx0) * (2*FracBits+1)'(wy0);
    w10_r <= (2*FracBits+1)'(dx_r) * (2*FracBits+1)'(wy0);
    w01_r <= (2*FracBits+1)'(wx0) * (2*FracBits+1)'(dy_r);
    w11_r <= (2*FracBits+1)'(dx_r) * (2*FracBits+1)'(dy_r);
  end

  logic [2*FracBits+9:0] s [0:2];
  logic [9:0] c [0:2];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s[k] = (2*FracBits+10)'(t_r[0][8*k +: 8]) * (2*FracBits+10)'(w00_r)
           + (2*FracBits+10)'(t_r[1][8*k +: 8]) * (2*FracBits+10)'(w10_r)
           + (2*FracBits+10)'(t_r[2][8*k +: 8]) * (2*FracBits+10)'(w01_r)
           + (2*FracBits+10)'(t_r[3][8*k +: 8]) * (2*FracBits+10)'(w11_r)
           + (2*FracBits+10)'(64'd1 << (2*FracBits-1));
      c[k] = s[k][2*FracBits+9:2*FracBits];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.blend) begin
      for (int k = 0; k < 3; k++) begin
        if (nearest_r) res_r[8*k +: 8] <= t_r[0][8*k +: 8];
        else res_r[8*k +: 8] <= (c[k] > 10'd255) ? 8'hFF : c[k][7:0];
      end
    end
  end
endmodule
`default_nettype wire

/* design/texture_sampler_bilinear.sv */
// ----------------------------------------------------------------------------
// texture_sampler_bilinear
// Bilinear or nearest RGB texture sampler with a 64K-texel internal store.
// ----------------------------------------------------------------------------
// A write is stored while the sampler stays idle. A sample passes the scale,
// address, fetch, blend and output states into the registered out_tdata; no
// new transaction is accepted until its result is loaded there. The four texel
// reads share the single port of the texel memory, one per cycle, and a result
// that is not taken holds the sampler and stalls the input.
// Reset restores 256 by 256 texels in bilinear mode; the store is not cleared.
`default_nettype none
module texture_sampler_bilinear (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // action, texel_addr, texel_red, texel_green, texel_blue, u_coord, v_coord
  input  wire logic [79:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_red, out_green, out_blue
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  import tsb_pkg::*;

  logic [8:0] w_r, h_r;
  logic       mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 9'd256; h_r <= 9'd256; mode_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegWidth:  w_r    <= cfg_data;
        RegHeight: h_r    <= cfg_data;
        RegMode:   mode_r <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  logic [8:0] w_eff, h_eff;
  assign w_eff = (w_r == 9'd0) ? 9'd1 : (w_r > 9'd256) ? 9'd256 : w_r;
  assign h_eff = (h_r == 9'd0) ? 9'd1 : (h_r > 9'd256) ? 9'd256 : h_r;

  cmd_t cmd;
  sts_t sts;
  logic busy, res_load, in_fire, ov_r;
  logic [23:0] res, od_r;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  tsb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(!ov_r || out_tready),
    .sts(sts), .cmd(cmd), .busy(busy), .res_load(res_load)
  );

  tsb_dp u_dp (
    .clk(clk), .cmd(cmd), .w_eff(w_eff), .h_eff(h_eff), .mode(mode_r),
    .action(in_tdata[0]), .texel_addr(in_tdata[16:1]),
    .texel_rgb({in_tdata[24:17], in_tdata[32:25], in_tdata[40:33]}),
    .u_coord(in_tdata[56:41]), .v_coord(in_tdata[72:57]),
    .sts(sts), .result(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (res_load) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
    if (res_load) od_r <= {res[7:0], res[15:8], res[23:16]};
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
endmodule
`default_nettype wire
